// ===== rtl/lew_pkg.sv =====
// Shared types, constants and key codes of the line editor.
package lew_pkg;

   // Buffer geometry.
   localparam int LINE_CAPACITY = 64;
   localparam int ADDR_W        = $clog2(LINE_CAPACITY);
   localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);

   // Fixed widths of the port fields.
   localparam int KEY_W = 8;
   localparam int POS_W = 6;
   localparam int LEN_W = 7;
   localparam int LIM_W = 7;

   // Widths wide enough for comparing count against position and limit.
   localparam int POS_CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int LIM_CMP_W = (LIM_W > CNT_W) ? LIM_W : CNT_W;

   // Value of the limit register after reset.
   localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(40);

   // Key codes.
   localparam logic [KEY_W-1:0] KEY_ERASE  = 8'd127;
   localparam logic [KEY_W-1:0] KEY_KILL   = 8'd21;
   localparam logic [KEY_W-1:0] KEY_WERASE = 8'd23;
   localparam logic [KEY_W-1:0] KEY_EOF    = 8'd4;
   localparam logic [KEY_W-1:0] KEY_SPACE  = 8'd32;
   localparam logic [KEY_W-1:0] PRINT_LOW  = 8'd32;
   localparam logic [KEY_W-1:0] PRINT_HIGH = 8'd126;

   // Source of the buffer read address.
   typedef enum logic [1:0] {
      ADDR_POS,
      ADDR_TOP,
      ADDR_BELOW
   } addr_sel_type;

   // Update applied to the character count.
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_req;
      logic         ram_read;
      addr_sel_type raddr_sel;
      logic         ram_write;
      cnt_op_type   cnt_op;
      logic         finish;
      logic         set_bell;
      logic         set_exit;
      logic         set_rdchar;
   } lew_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_read;
      logic key_eof;
      logic key_erase;
      logic key_kill;
      logic key_werase;
      logic key_print;
      logic count_zero;
      logic count_one;
      logic can_append;
      logic char_space;
   } lew_stat_type;

endpackage

// ===== rtl/lew_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lew_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lew_dp.sv =====
// Datapath of the line editor: request latch, count, limit, line buffer and result registers.
module lew_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_op,
   input  logic [lew_pkg::KEY_W-1:0]    req_key_byte,
   input  logic [lew_pkg::POS_W-1:0]    req_position,
   input  logic                         csr_write_enable,
   input  logic [lew_pkg::LIM_W-1:0]    csr_write_data,
   input  lew_pkg::lew_cmd_type         cmd,
   output lew_pkg::lew_stat_type        stat,
   output logic [lew_pkg::LEN_W-1:0]    rsp_line_length,
   output logic                         rsp_bell,
   output logic                         rsp_exit_request,
   output logic [lew_pkg::KEY_W-1:0]    rsp_read_char
);

   logic                         op_ff;
   logic [lew_pkg::KEY_W-1:0]    key_ff;
   logic [lew_pkg::POS_W-1:0]    pos_ff;
   logic [lew_pkg::CNT_W-1:0]    count_ff;
   logic [lew_pkg::CNT_W-1:0]    count_in;
   logic [lew_pkg::LIM_W-1:0]    limit_ff;
   logic                         bell_ff;
   logic                         exit_ff;
   logic [lew_pkg::KEY_W-1:0]    rdchar_ff;
   logic [lew_pkg::KEY_W-1:0]    rdchar_in;
   logic [lew_pkg::ADDR_W-1:0]   raddr;
   logic [lew_pkg::ADDR_W-1:0]   waddr;
   logic [lew_pkg::KEY_W-1:0]    rdata;
   logic                         pos_in_range;

   // Latch the request beat when it is accepted.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_op;
         key_ff <= req_key_byte;
         pos_ff <= req_position;
      end
   end

   // Line limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= lew_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // Character count update.
   always_comb begin
      case (cmd.cnt_op)
         lew_pkg::CNT_INC:   count_in = count_ff + lew_pkg::CNT_W'(1);
         lew_pkg::CNT_DEC:   count_in = count_ff - lew_pkg::CNT_W'(1);
         lew_pkg::CNT_CLEAR: count_in = '0;
         default:            count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Buffer addresses: the read either serves a position or walks down from the end.
   always_comb begin
      case (cmd.raddr_sel)
         lew_pkg::ADDR_POS:   raddr = lew_pkg::ADDR_W'(pos_ff);
         lew_pkg::ADDR_TOP:   raddr = lew_pkg::ADDR_W'(count_ff - lew_pkg::CNT_W'(1));
         lew_pkg::ADDR_BELOW: raddr = lew_pkg::ADDR_W'(count_ff - lew_pkg::CNT_W'(2));
         default:             raddr = lew_pkg::ADDR_W'(pos_ff);
      endcase
   end

   assign waddr = lew_pkg::ADDR_W'(count_ff);

   lew_ram #(
      .DATA_W (lew_pkg::KEY_W),
      .DEPTH  (lew_pkg::LINE_CAPACITY)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.ram_write),
      .wr_addr (waddr),
      .wr_data (key_ff),
      .rd_en   (cmd.ram_read),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   // Key classification and count checks for the controller.
   assign pos_in_range = lew_pkg::POS_CMP_W'(pos_ff) < lew_pkg::POS_CMP_W'(count_ff);

   always_comb begin
      stat.op_read    = op_ff;
      stat.key_eof    = (key_ff == lew_pkg::KEY_EOF);
      stat.key_erase  = (key_ff == lew_pkg::KEY_ERASE);
      stat.key_kill   = (key_ff == lew_pkg::KEY_KILL);
      stat.key_werase = (key_ff == lew_pkg::KEY_WERASE);
      stat.key_print  = (key_ff >= lew_pkg::PRINT_LOW) && (key_ff <= lew_pkg::PRINT_HIGH);
      stat.count_zero = (count_ff == '0);
      stat.count_one  = (count_ff == lew_pkg::CNT_W'(1));
      stat.can_append = (lew_pkg::LIM_CMP_W'(count_ff) < lew_pkg::LIM_CMP_W'(limit_ff)) &&
                        (count_ff < lew_pkg::CNT_W'(lew_pkg::LINE_CAPACITY));
      stat.char_space = (rdata == lew_pkg::KEY_SPACE);
   end

   // Result registers, loaded when the controller finishes an item.
   assign rdchar_in = (cmd.set_rdchar && pos_in_range) ? rdata : '0;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         bell_ff   <= cmd.set_bell;
         exit_ff   <= cmd.set_exit;
         rdchar_ff <= rdchar_in;
      end
   end

   assign rsp_line_length  = lew_pkg::LEN_W'(count_ff);
   assign rsp_bell         = bell_ff;
   assign rsp_exit_request = exit_ff;
   assign rsp_read_char    = rdchar_ff;

   // The count never passes the buffer size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lew_pkg::CNT_W'(lew_pkg::LINE_CAPACITY))
      else $error("character count beyond buffer capacity");

   // A character is stored only when the line has room under the limit.
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_write |-> stat.can_append)
      else $error("buffer write on a full line");

   // A stored character always lengthens the line by one.
   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_write |=> count_ff == $past(count_ff) + lew_pkg::CNT_W'(1))
      else $error("buffer write without count increment");

endmodule

// ===== rtl/lew_ctrl.sv =====
// Controller of the line editor: sequences decode, buffer reads and the word erase walk.
module lew_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lew_pkg::lew_stat_type stat,
   output lew_pkg::lew_cmd_type  cmd,
   output logic                  rsp_strobe
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_SKIP,
      ST_WORD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      strobe_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.raddr_sel  = lew_pkg::ADDR_POS;
      cmd.cnt_op     = lew_pkg::CNT_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (stat.op_read) begin
               cmd.ram_read  = 1'b1;
               cmd.raddr_sel = lew_pkg::ADDR_POS;
               state_in      = ST_READ;
            end else if (stat.key_eof && stat.count_zero) begin
               cmd.finish   = 1'b1;
               cmd.set_exit = 1'b1;
            end else if (stat.key_erase) begin
               cmd.finish = 1'b1;
               if (!stat.count_zero) begin
                  cmd.cnt_op = lew_pkg::CNT_DEC;
               end
            end else if (stat.key_kill) begin
               cmd.finish = 1'b1;
               cmd.cnt_op = lew_pkg::CNT_CLEAR;
            end else if (stat.key_werase) begin
               if (stat.count_zero) begin
                  cmd.finish = 1'b1;
               end else begin
                  cmd.ram_read  = 1'b1;
                  cmd.raddr_sel = lew_pkg::ADDR_TOP;
                  state_in      = ST_SKIP;
               end
            end else if (stat.key_print && stat.can_append) begin
               cmd.finish    = 1'b1;
               cmd.ram_write = 1'b1;
               cmd.cnt_op    = lew_pkg::CNT_INC;
            end else begin
               cmd.finish   = 1'b1;
               cmd.set_bell = 1'b1;
            end
         end
         ST_READ: begin
            cmd.finish     = 1'b1;
            cmd.set_rdchar = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SKIP, ST_WORD: begin
            // A space ends the word once the trailing spaces are gone.
            if (state_ff == ST_WORD && stat.char_space) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.cnt_op = lew_pkg::CNT_DEC;
               if (stat.count_one) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.ram_read  = 1'b1;
                  cmd.raddr_sel = lew_pkg::ADDR_BELOW;
                  state_in      = stat.char_space ? ST_SKIP : ST_WORD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.finish;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

   // Results are never presented back to back.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for two cycles");

   // The result beat always comes out while the controller is idle again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> state_ff == ST_IDLE)
      else $error("result strobe while busy");

   // An accepted request is decoded in the next cycle.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == ST_IDLE) |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");

endmodule

// ===== rtl/line_editor_erase_kill_werase.sv =====
// Top level of the console line editor: controller and datapath.
//
// Each request beat (start while busy is low) produces exactly one result
// beat, shown on the rsp_ ports for one cycle under rsp_strobe; the receiver
// cannot hold results off, so it must take every beat as it comes. A key byte
// other than word erase gives its result after decode, and a read after
// decode and the registered read of the line buffer. Word erase walks the
// buffer down from the end through its single read port, one character per
// cycle, removing trailing spaces and then the word before them. busy is low
// again in the cycle of the result beat, so a new request can be accepted
// there. The line limit is written through csr_write_enable and
// csr_write_data; the user must do so only while no request is in progress,
// which the block itself does not enforce. A limit above the buffer size acts
// as the buffer size.
module line_editor_erase_kill_werase (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_op,
   input  logic [lew_pkg::KEY_W-1:0] req_key_byte,
   input  logic [lew_pkg::POS_W-1:0] req_position,
   output logic                      rsp_strobe,
   output logic [lew_pkg::LEN_W-1:0] rsp_line_length,
   output logic                      rsp_bell,
   output logic                      rsp_exit_request,
   output logic [lew_pkg::KEY_W-1:0] rsp_read_char,
   input  logic                      csr_write_enable,
   input  logic [lew_pkg::LIM_W-1:0] csr_write_data
);

   lew_pkg::lew_cmd_type  cmd;
   lew_pkg::lew_stat_type stat;

   // Sequencing.
   lew_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .stat       (stat),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   // Storage and arithmetic.
   lew_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_key_byte     (req_key_byte),
      .req_position     (req_position),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_line_length  (rsp_line_length),
      .rsp_bell         (rsp_bell),
      .rsp_exit_request (rsp_exit_request),
      .rsp_read_char    (rsp_read_char)
   );

endmodule

// ===== bench/line_editor_erase_kill_werase_tb.sv =====
// Self-checking testbench for the console line editor, with its scoreboard class.

// One result beat of the editor, as predicted or as seen on the rsp_ ports.
typedef struct packed {
   logic [lew_pkg::LEN_W-1:0] line_length;
   logic                      bell;
   logic                      exit_request;
   logic [lew_pkg::KEY_W-1:0] read_char;
} edit_result_type;

// Mirror of the line buffer that predicts each result and checks it on arrival.
class line_scoreboard;
   logic [lew_pkg::KEY_W-1:0] line_chars [lew_pkg::LINE_CAPACITY];
   int unsigned               char_count;
   int unsigned               line_limit;
   edit_result_type           due_results [$];
   int unsigned               failures;
   int unsigned               requests;
   int unsigned               responses;
   int unsigned               bells;
   int unsigned               exits;
   int unsigned               longest_line;

   function new();
      foreach (line_chars[i]) line_chars[i] = '0;
      char_count   = 0;
      line_limit   = lew_pkg::LIMIT_RESET;
      failures     = 0;
      requests     = 0;
      responses    = 0;
      bells        = 0;
      exits        = 0;
      longest_line = 0;
   endfunction

   function void set_limit(logic [lew_pkg::LIM_W-1:0] value);
      line_limit = value;
   endfunction

   // Apply one accepted request beat to the mirror and queue its result.
   function void note_request(logic op, logic [lew_pkg::KEY_W-1:0] key,
                              logic [lew_pkg::POS_W-1:0] pos);
      edit_result_type due;
      int unsigned     room;
      due  = '0;
      room = (line_limit > lew_pkg::LINE_CAPACITY) ? lew_pkg::LINE_CAPACITY : line_limit;
      if (op == 1'b1) begin
         if (pos < char_count) due.read_char = line_chars[pos];
      end else if (key == lew_pkg::KEY_EOF && char_count == 0) begin
         due.exit_request = 1'b1;
      end else if (key == lew_pkg::KEY_ERASE) begin
         if (char_count > 0) char_count--;
      end else if (key == lew_pkg::KEY_KILL) begin
         char_count = 0;
      end else if (key == lew_pkg::KEY_WERASE) begin
         // Trailing spaces go first, then the word in front of them.
         while (char_count > 0 && line_chars[char_count-1] == lew_pkg::KEY_SPACE)
            char_count--;
         while (char_count > 0 && line_chars[char_count-1] != lew_pkg::KEY_SPACE)
            char_count--;
      end else if (key >= lew_pkg::PRINT_LOW && key <= lew_pkg::PRINT_HIGH) begin
         if (char_count < room) begin
            line_chars[char_count] = key;
            char_count++;
         end else begin
            due.bell = 1'b1;
         end
      end else begin
         due.bell = 1'b1;
      end
      due.line_length = char_count[lew_pkg::LEN_W-1:0];
      if (char_count > longest_line) longest_line = char_count;
      bells += due.bell;
      exits += due.exit_request;
      requests++;
      due_results.push_back(due);
   endfunction

   function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   // Compare one result beat with the oldest prediction.
   function void check_response(edit_result_type got);
      edit_result_type want;
      responses++;
      if (due_results.size() == 0) begin
         failures++;
         $display("%0t: result beat with nothing expected, expected none, actual %h",
                  $time, got);
         return;
      end
      want = due_results.pop_front();
      compare_field("line_length", 8'(want.line_length), 8'(got.line_length));
      compare_field("bell", 8'(want.bell), 8'(got.bell));
      compare_field("exit_request", 8'(want.exit_request), 8'(got.exit_request));
      compare_field("read_char", want.read_char, got.read_char);
   endfunction
endclass

module line_editor_erase_kill_werase_tb;
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;
   localparam int   CYCLE_LIMIT = 400000;
   localparam int   ITEMS_PER_PHASE = 62;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_op;
   logic [lew_pkg::KEY_W-1:0] req_key_byte;
   logic [lew_pkg::POS_W-1:0] req_position;
   logic                      rsp_strobe;
   logic [lew_pkg::LEN_W-1:0] rsp_line_length;
   logic                      rsp_bell;
   logic                      rsp_exit_request;
   logic [lew_pkg::KEY_W-1:0] rsp_read_char;
   logic                      csr_write_enable;
   logic [lew_pkg::LIM_W-1:0] csr_write_data;

   line_scoreboard book;
   int unsigned    cycle_count;
   int unsigned    limit_settings;

   line_editor_erase_kill_werase dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_key_byte     (req_key_byte),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_line_length  (rsp_line_length),
      .rsp_bell         (rsp_bell),
      .rsp_exit_request (rsp_exit_request),
      .rsp_read_char    (rsp_read_char),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a run that hangs ends here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Monitor: take request beats and result beats at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            book.check_response('{rsp_line_length, rsp_bell, rsp_exit_request, rsp_read_char});
         if (start && !busy)
            book.note_request(req_op, req_key_byte, req_position);
      end
   end

   // Present one request beat and hold it until the editor takes it.
   task automatic send_beat(input logic op, input logic [lew_pkg::KEY_W-1:0] key,
                            input logic [lew_pkg::POS_W-1:0] pos);
      @(negedge clock);
      start        = 1'b1;
      req_op       = op;
      req_key_byte = key;
      req_position = pos;
      do @(posedge clock); while (busy);
   endtask

   // Key beat with a random, unused position field.
   task automatic type_key(input logic [lew_pkg::KEY_W-1:0] key);
      send_beat(OP_KEY, key, lew_pkg::POS_W'($urandom));
   endtask

   // Read beat with a random, unused key field.
   task automatic read_at(input logic [lew_pkg::POS_W-1:0] pos);
      send_beat(OP_READ, lew_pkg::KEY_W'($urandom), pos);
   endtask

   task automatic hold_off(input int unsigned cycles);
      if (cycles != 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Stop sending and wait until every result has come back.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (book.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the line limit while the editor is idle.
   task automatic write_limit(input logic [lew_pkg::LIM_W-1:0] value);
      drain();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data   = lew_pkg::LIM_W'($urandom);
      book.set_limit(value);
      limit_settings++;
   endtask

   // One random beat, weighted towards typing words so lines grow.
   task automatic random_beat();
      int unsigned pick;
      int unsigned held;
      pick = $urandom_range(0, 99);
      held = book.char_count;
      if (pick < 40)      type_key(lew_pkg::KEY_W'($urandom_range(33, 126)));
      else if (pick < 50) type_key(lew_pkg::KEY_SPACE);
      else if (pick < 57) type_key(lew_pkg::KEY_ERASE);
      else if (pick < 60) type_key(lew_pkg::KEY_KILL);
      else if (pick < 68) type_key(lew_pkg::KEY_WERASE);
      else if (pick < 71) type_key(lew_pkg::KEY_EOF);
      else if (pick < 76) begin
         // Noise: control bytes and bytes with the top bit set.
         if ($urandom_range(0, 1) == 0) type_key(lew_pkg::KEY_W'($urandom_range(0, 31)));
         else                           type_key(lew_pkg::KEY_W'($urandom_range(128, 255)));
      end else begin
         if (held > 0 && $urandom_range(0, 1) == 0)
            read_at(lew_pkg::POS_W'($urandom_range(0, held - 1)));
         else
            read_at(lew_pkg::POS_W'($urandom_range(0, 63)));
      end
   endtask

   // Random beats in bursts, with gaps unless the phase runs flat out.
   task automatic random_phase(input int unsigned items, input bit no_gaps);
      int unsigned burst;
      while (items > 0) begin
         burst = $urandom_range(1, 12);
         if (burst > items) burst = items;
         items -= burst;
         repeat (burst) random_beat();
         if (!no_gaps)
            hold_off(($urandom_range(0, 9) == 0) ? $urandom_range(10, 70)
                                                 : $urandom_range(0, 4));
      end
   endtask

   initial begin
      logic [lew_pkg::LIM_W-1:0] phase_limits [8];
      book             = new();
      limit_settings   = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_op           = OP_KEY;
      req_key_byte     = '0;
      req_position     = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty line: exit request, reads and edits with nothing to remove.
      type_key(lew_pkg::KEY_EOF);
      read_at(6'd0);
      read_at(6'd63);
      type_key(lew_pkg::KEY_ERASE);
      type_key(lew_pkg::KEY_WERASE);
      type_key(lew_pkg::KEY_KILL);

      // Printable extremes and words split by runs of spaces.
      type_key(lew_pkg::PRINT_LOW);
      type_key("a");
      type_key("b");
      type_key(lew_pkg::KEY_SPACE);
      type_key(lew_pkg::KEY_SPACE);
      type_key(lew_pkg::PRINT_HIGH);
      type_key("c");
      type_key(lew_pkg::KEY_SPACE);
      read_at(6'd0);
      read_at(6'd7);
      read_at(6'd8);
      type_key(lew_pkg::KEY_WERASE);

      // Rejected bytes on a non-empty line, including end-of-input.
      type_key(lew_pkg::KEY_EOF);
      type_key(8'd0);
      type_key(8'd255);
      type_key(8'd128);
      type_key(8'd31);
      type_key(lew_pkg::KEY_WERASE);
      type_key(lew_pkg::KEY_WERASE);
      type_key("x");
      type_key(lew_pkg::KEY_ERASE);
      type_key("y");
      type_key(lew_pkg::KEY_KILL);

      // Limit of one: the second character rings the bell.
      write_limit(7'd1);
      type_key("p");
      type_key("q");
      type_key(lew_pkg::KEY_KILL);

      // Full buffer of one long word, then a limit below the length.
      write_limit(7'd64);
      for (int i = 0; i < lew_pkg::LINE_CAPACITY; i++)
         type_key(lew_pkg::KEY_W'("A" + (i % 26)));
      type_key("z");
      read_at(6'd63);
      write_limit(7'd5);
      type_key("z");
      type_key(lew_pkg::KEY_WERASE);
      read_at(6'd0);

      // Random phases over a spread of limits, the extremes among them.
      phase_limits = '{7'd127, 7'd64, lew_pkg::LIM_W'($urandom_range(1, 64)), 7'd2,
                       7'd0, 7'd64, lew_pkg::LIM_W'($urandom_range(65, 127)), 7'd40};
      foreach (phase_limits[p]) begin
         write_limit(phase_limits[p]);
         random_phase(ITEMS_PER_PHASE, p == 5);
      end

      // Let the last results arrive, then allow for a full-line word erase.
      drain();
      repeat (70) @(posedge clock);
      if (book.due_results.size() != 0) begin
         book.failures++;
         $display("%0t: results still outstanding, expected 0, actual %0d",
                  $time, book.due_results.size());
      end

      $display("Covered %0d request beats and %0d result beats under %0d limit settings.",
               book.requests, book.responses, limit_settings);
      $display("Bells rung: %0d, exit requests: %0d, longest line held: %0d characters.",
               book.bells, book.exits, book.longest_line);
      if (book.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/lew_pkg.sv
rtl/lew_ram.sv
rtl/lew_dp.sv
rtl/lew_ctrl.sv
rtl/line_editor_erase_kill_werase.sv
bench/line_editor_erase_kill_werase_tb.sv
